### src/nnis_pkg.sv
// Shared types, constants and pipeline helper functions of the nearest-neighbour image scaler.
`default_nettype none
package nnis_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_DST_DIM    = 4096;

  localparam int COORD_W   = 12;
  localparam int SRC_DIM_W = 9;
  localparam int DST_DIM_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam int PIX_W     = 32;

  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // A scaled coordinate of an in-range fetch is below the source size, so it fits in QBITS bits.
  localparam int MAX_SRC_DIM = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
  localparam int QBITS       = $clog2(MAX_SRC_DIM);
  localparam int QIDX_W      = (QBITS > 1) ? $clog2(QBITS) : 1;
  localparam int NUM_W       = COORD_W + SRC_DIM_W;
  localparam int DIV_STAGES  = QBITS;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = CFG_IDX_W'(3);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [7:0]         alpha_in;
  } in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       out_of_range;
  } out_t;

  typedef struct packed {
    logic              fetch;
    logic              wr_ok;
    logic              oor;
    logic              empty;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  pixel;
    logic [NUM_W-1:0]  rem_x;
    logic [NUM_W-1:0]  rem_y;
    logic [QBITS-1:0]  q_x;
    logic [QBITS-1:0]  q_y;
  } pipe_t;

  function automatic logic [SRC_DIM_W-1:0] clamp_src(logic [SRC_DIM_W-1:0] v,
                                                     logic [SRC_DIM_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [DST_DIM_W-1:0] clamp_dst(logic [DST_DIM_W-1:0] v);
    return (v > DST_DIM_W'(MAX_DST_DIM)) ? DST_DIM_W'(MAX_DST_DIM) : v;
  endfunction

  // Range checks, write address and the two products that feed the dividers.
  function automatic pipe_t mul_stage(in_t it,
                                      logic [SRC_DIM_W-1:0] sw, logic [SRC_DIM_W-1:0] sh,
                                      logic [DST_DIM_W-1:0] dw, logic [DST_DIM_W-1:0] dh);
    pipe_t r;
    r.fetch = (it.action == ACT_FETCH);
    r.wr_ok = (it.action == ACT_WRITE) && (NUM_W'(it.coord_x) < NUM_W'(sw))
              && (NUM_W'(it.coord_y) < NUM_W'(sh));
    r.oor   = (NUM_W'(it.coord_x) >= NUM_W'(dw)) || (NUM_W'(it.coord_y) >= NUM_W'(dh));
    r.empty = (sw == '0) || (sh == '0);
    r.waddr = ADDR_W'(32'(it.coord_y) * MAX_SRC_WIDTH + 32'(it.coord_x));
    r.pixel = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
    r.rem_x = NUM_W'(it.coord_x) * NUM_W'(sw);
    r.rem_y = NUM_W'(it.coord_y) * NUM_W'(sh);
    r.q_x   = '0;
    r.q_y   = '0;
    return r;
  endfunction

  // One restoring division step for each axis, producing quotient bit b.
  function automatic pipe_t div_step(pipe_t p, logic [DST_DIM_W-1:0] dw,
                                     logic [DST_DIM_W-1:0] dh, logic [QIDX_W-1:0] b);
    pipe_t            r;
    logic [NUM_W-1:0] tx;
    logic [NUM_W-1:0] ty;
    r  = p;
    tx = NUM_W'(dw) << b;
    ty = NUM_W'(dh) << b;
    if (r.rem_x >= tx) begin
      r.rem_x  = r.rem_x - tx;
      r.q_x[b] = 1'b1;
    end
    if (r.rem_y >= ty) begin
      r.rem_y  = r.rem_y - ty;
      r.q_y[b] = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/nnis_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module nnis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/nearest_neighbor_image_scaler_unit.sv
// Top level of the nearest-neighbour image scaler: pipeline, configuration and pixel store.
//
// Items arrive on in_valid/in_ready as in_t. A write item stores an RGBA pixel at its
// source column and row (ignored outside the source size) and gives no result. A fetch
// item names a destination pixel and gives one out_t result on out_valid/out_ready.
// Sizes are set through cfg_valid/cfg_ready/cfg_index/cfg_data while no item is in
// flight; cfg_ready is always high.
// The pipeline takes one item per cycle while results are not stalled. A fetch result
// passes through an input register, a multiply stage, one stage per quotient
// bit of the two scale divisions (eight for 256-pixel sources), and the registered
// read of the pixel store. Writes enter the store at the same point in the pipeline
// as fetches read it, so a fetch always sees every write accepted before it.
// When the receiver stalls, the result is held and the stages behind it keep moving
// until they fill; in_ready falls only when every stage up to the input holds an item.
// Reset empties the pipeline and sets the source size to zero and the destination
// size to one; the store is not cleared, so a pixel is only valid once written.
`default_nettype none
module nearest_neighbor_image_scaler_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire nnis_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output nnis_pkg::out_t                         out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nnis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nnis_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import nnis_pkg::*;

  localparam int L = DIV_STAGES;

  logic [SRC_DIM_W-1:0] sw;
  logic [SRC_DIM_W-1:0] sh;
  logic [DST_DIM_W-1:0] dw;
  logic [DST_DIM_W-1:0] dh;

  logic  in_v;
  in_t   in_r;
  logic  in_free;

  pipe_t      st [0:L];
  logic [L:0] st_v;
  logic [L:0] st_free;
  logic       go_r;

  logic       out_v;
  logic       out_free;
  logic       out_oor;
  logic       out_zero;

  logic [SRC_DIM_W-1:0] qx_w;
  logic [SRC_DIM_W-1:0] qy_w;
  logic [SRC_DIM_W-1:0] sx;
  logic [SRC_DIM_W-1:0] sy;
  logic [ADDR_W-1:0]    raddr;
  logic                 ram_we;
  logic                 ram_re;
  logic [PIX_W-1:0]     rdata;

  // Configuration registers hold the sizes already clamped to their maxima.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= '0;
      sh <= '0;
      dw <= DST_DIM_W'(1);
      dh <= DST_DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_WIDTH:  sw <= clamp_src(cfg_data[SRC_DIM_W-1:0], SRC_DIM_W'(MAX_SRC_WIDTH));
        REG_SRC_HEIGHT: sh <= clamp_src(cfg_data[SRC_DIM_W-1:0], SRC_DIM_W'(MAX_SRC_HEIGHT));
        REG_DST_WIDTH:  dw <= clamp_dst(cfg_data[DST_DIM_W-1:0]);
        REG_DST_HEIGHT: dh <= clamp_dst(cfg_data[DST_DIM_W-1:0]);
        default: ;
      endcase
    end
  end

  // Stall chain: a stage may load when it is empty or its item moves on.
  // A write leaves the last stage without needing room in the output register.
  assign out_free   = !out_v || out_ready;
  assign go_r       = st_v[L] && (!st[L].fetch || out_free);
  assign st_free[L] = !st_v[L] || go_r;

  for (genvar k = 0; k < L; k++) begin : g_free
    assign st_free[k] = !st_v[k] || st_free[k+1];
  end

  assign in_free  = !in_v || st_free[0];
  assign in_ready = in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_free) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (st_free[0]) begin
      st_v[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (st_free[0]) begin
      st[0] <= mul_stage(in_r, sw, sh, dw, dh);
    end
  end

  for (genvar k = 1; k <= L; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k] <= 1'b0;
      end else if (st_free[k]) begin
        st_v[k] <= st_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (st_free[k]) begin
        st[k] <= div_step(st[k-1], dw, dh, QIDX_W'(QBITS - k));
      end
    end
  end

  // Source coordinates, clamped to the last column and row.
  assign qx_w  = SRC_DIM_W'(st[L].q_x);
  assign qy_w  = SRC_DIM_W'(st[L].q_y);
  assign sx    = (qx_w >= sw) ? sw - SRC_DIM_W'(1) : qx_w;
  assign sy    = (qy_w >= sh) ? sh - SRC_DIM_W'(1) : qy_w;
  assign raddr = ADDR_W'(32'(sy) * MAX_SRC_WIDTH + 32'(sx));

  assign ram_we = go_r && !st[L].fetch && st[L].wr_ok;
  assign ram_re = out_free && st_v[L] && st[L].fetch;

  nnis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (st[L].waddr),
    .wdata (st[L].pixel),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_free) begin
      out_v <= st_v[L] && st[L].fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_oor  <= st[L].oor;
      out_zero <= st[L].oor || st[L].empty;
    end
  end

  assign out_valid              = out_v;
  assign out_data.red_out       = out_zero ? 8'd0 : rdata[7:0];
  assign out_data.green_out     = out_zero ? 8'd0 : rdata[15:8];
  assign out_data.blue_out      = out_zero ? 8'd0 : rdata[23:16];
  assign out_data.alpha_out     = out_zero ? 8'd0 : rdata[31:24];
  assign out_data.out_of_range  = out_oor;

endmodule
`default_nettype wire

### src/nnis_checker.sv
// Port-level checks of the nearest-neighbour image scaler and their binding to the top level.
`default_nettype none
module nnis_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire nnis_pkg::out_t out_data
);

  // The pipeline is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown in the cycle after reset");

  // With no result waiting every stage drains, so the input must be open.
  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while no result is waiting");

  // An out-of-range fetch carries no colour.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_of_range |->
      out_data.red_out == 8'd0 && out_data.green_out == 8'd0 &&
      out_data.blue_out == 8'd0 && out_data.alpha_out == 8'd0)
    else $error("out-of-range result with non-zero colour");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

endmodule

bind nearest_neighbor_image_scaler_unit nnis_checker u_nnis_checker (.*);
`default_nettype wire

### bench/nearest_neighbor_image_scaler_unit_tb.sv
// Self-checking testbench of the nearest-neighbour image scaler with a built-in pixel predictor.
`default_nettype none
module nearest_neighbor_image_scaler_unit_tb;
  import nnis_pkg::*;

  localparam int RANDOM_ITEMS = 1030;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic {STEP_CFG, STEP_ITEM} step_kind_e;

  typedef struct {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] reg_value;
    in_t                  item;
    bit                   typed;
    out_t                 typed_result;
  } plan_step_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  // Sizes as last written, before clamping.
  logic [SRC_DIM_W-1:0] img_src_w = '0;
  logic [SRC_DIM_W-1:0] img_src_h = '0;
  logic [DST_DIM_W-1:0] img_dst_w = DST_DIM_W'(1);
  logic [DST_DIM_W-1:0] img_dst_h = DST_DIM_W'(1);

  logic [PIX_W-1:0] source_pixels [0:STORE_DEPTH-1];
  bit               pixel_written [0:STORE_DEPTH-1];
  out_t             expected_pixels [$];
  plan_step_t       plan [$];

  bit steady_flow = 1'b0;
  int errors = 0;
  int results_seen = 0;
  int fetches = 0;
  int fetches_outside = 0;
  int writes_stored = 0;
  int writes_ignored = 0;
  int size_settings = 0;

  nearest_neighbor_image_scaler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 30) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // Store address read by a fetch, or -1 when the fetch reads nothing.
  function automatic int fetch_addr(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int unsigned sw, sh, dw, dh, sx, sy;
    sw = clamp_dim(img_src_w, MAX_SRC_WIDTH);
    sh = clamp_dim(img_src_h, MAX_SRC_HEIGHT);
    dw = clamp_dim(img_dst_w, MAX_DST_DIM);
    dh = clamp_dim(img_dst_h, MAX_DST_DIM);
    if (x >= dw || y >= dh || sw == 0 || sh == 0) return -1;
    sx = (x * sw) / dw;
    sy = (y * sh) / dh;
    if (sx > sw - 1) sx = sw - 1;
    if (sy > sh - 1) sy = sh - 1;
    return int'(sy * MAX_SRC_WIDTH + sx);
  endfunction

  function automatic out_t scaled_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    out_t r;
    int   a;
    r = '0;
    a = fetch_addr(x, y);
    if (a >= 0)
      {r.alpha_out, r.blue_out, r.green_out, r.red_out} = source_pixels[a];
    else
      r.out_of_range = (x >= clamp_dim(img_dst_w, MAX_DST_DIM)) ||
                       (y >= clamp_dim(img_dst_h, MAX_DST_DIM));
    return r;
  endfunction

  function automatic in_t pixel_item(logic act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                     logic [PIX_W-1:0] abgr);
    in_t it;
    it.action  = act;
    it.coord_x = x;
    it.coord_y = y;
    {it.alpha_in, it.blue_in, it.green_in, it.red_in} = abgr;
    return it;
  endfunction

  // Updates the predicted store for a write, or queues the pixel a fetch must return.
  task automatic take_item(in_t it, bit typed, out_t typed_result);
    int unsigned sw, sh;
    int          a;
    out_t        want;
    sw = clamp_dim(img_src_w, MAX_SRC_WIDTH);
    sh = clamp_dim(img_src_h, MAX_SRC_HEIGHT);
    if (it.action == ACT_WRITE) begin
      if (it.coord_x < sw && it.coord_y < sh) begin
        a = int'(it.coord_y) * MAX_SRC_WIDTH + int'(it.coord_x);
        source_pixels[a] = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
        pixel_written[a] = 1'b1;
        writes_stored++;
      end else begin
        writes_ignored++;
      end
    end else begin
      want = typed ? typed_result : scaled_pixel(it.coord_x, it.coord_y);
      if (want.out_of_range) fetches_outside++;
      fetches++;
      expected_pixels.insert(expected_pixels.size(), want);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(in_t it, bit typed, out_t typed_result);
    while (!steady_flow && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    take_item(it, typed, typed_result);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SRC_WIDTH:  img_src_w = value[SRC_DIM_W-1:0];
      REG_SRC_HEIGHT: img_src_h = value[SRC_DIM_W-1:0];
      REG_DST_WIDTH:  img_dst_w = value[DST_DIM_W-1:0];
      REG_DST_HEIGHT: img_dst_h = value[DST_DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Writes give no result, so a few more cycles pass once the last fetch is back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    plan_step_t s;
    s = '{STEP_CFG, idx, value, '0, 1'b0, '0};
    plan.insert(plan.size(), s);
  endfunction

  function automatic void plan_item(logic act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                    logic [PIX_W-1:0] abgr, bit typed,
                                    logic [PIX_W-1:0] want_abgr, logic want_oor);
    plan_step_t s;
    out_t       want;
    {want.alpha_out, want.blue_out, want.green_out, want.red_out} = want_abgr;
    want.out_of_range = want_oor;
    s = '{STEP_ITEM, '0, '0, pixel_item(act, x, y, abgr), typed, want};
    plan.insert(plan.size(), s);
  endfunction

  always @(negedge clk) out_ready <= steady_flow || ($urandom_range(99) >= 30);

  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.red_out !== want.red_out)
          flag_error($sformatf("result %0d red %h, expected %h",
                               results_seen, out_data.red_out, want.red_out));
        if (out_data.green_out !== want.green_out)
          flag_error($sformatf("result %0d green %h, expected %h",
                               results_seen, out_data.green_out, want.green_out));
        if (out_data.blue_out !== want.blue_out)
          flag_error($sformatf("result %0d blue %h, expected %h",
                               results_seen, out_data.blue_out, want.blue_out));
        if (out_data.alpha_out !== want.alpha_out)
          flag_error($sformatf("result %0d alpha %h, expected %h",
                               results_seen, out_data.alpha_out, want.alpha_out));
        if (out_data.out_of_range !== want.out_of_range)
          flag_error($sformatf("result %0d out_of_range %b, expected %b",
                               results_seen, out_data.out_of_range, want.out_of_range));
      end
    end
  end

  initial begin : stimulus
    in_t                  it;
    logic                 act;
    logic [COORD_W-1:0]   x, y;
    logic [SRC_DIM_W-1:0] new_sw, new_sh;
    logic [DST_DIM_W-1:0] new_dw, new_dh;
    int unsigned          sw, sh, dw, dh, pick, phase_len, counted, base;
    int                   a;
    bit                   in_cfg;

    // After reset the source is empty and the destination is one pixel.
    plan_item(ACT_FETCH, 12'd0, 12'd0, 32'h0, 1'b1, 32'h0, 1'b0);
    plan_item(ACT_FETCH, 12'd1, 12'd0, 32'h0, 1'b1, 32'h0, 1'b1);
    plan_item(ACT_FETCH, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1);
    plan_item(ACT_WRITE, 12'd0, 12'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
    // Largest legal sizes on both sides.
    plan_cfg(REG_SRC_WIDTH, 13'd256);
    plan_cfg(REG_SRC_HEIGHT, 13'd256);
    plan_cfg(REG_DST_WIDTH, 13'd4096);
    plan_cfg(REG_DST_HEIGHT, 13'd4096);
    plan_item(ACT_WRITE, 12'd0, 12'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
    plan_item(ACT_WRITE, 12'd255, 12'd255, 32'h8004_0201, 1'b0, 32'h0, 1'b0);
    plan_item(ACT_WRITE, 12'd0, 12'd1, 32'h3CC3_5AA5, 1'b0, 32'h0, 1'b0);
    // Column 256 of row 0 would alias row 1 if the range check were missing.
    plan_item(ACT_WRITE, 12'd256, 12'd0, 32'h0, 1'b0, 32'h0, 1'b0);
    plan_item(ACT_FETCH, 12'd0, 12'd0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    plan_item(ACT_FETCH, 12'hFFF, 12'hFFF, 32'h0, 1'b1, 32'h8004_0201, 1'b0);
    plan_item(ACT_FETCH, 12'd0, 12'd16, 32'h0, 1'b1, 32'h3CC3_5AA5, 1'b0);
    // Oversized settings act as the largest ones.
    plan_cfg(REG_SRC_WIDTH, 13'd511);
    plan_cfg(REG_SRC_HEIGHT, 13'd300);
    plan_cfg(REG_DST_WIDTH, 13'd8191);
    plan_cfg(REG_DST_HEIGHT, 13'd8191);
    plan_item(ACT_WRITE, 12'd300, 12'd0, 32'h1234_5678, 1'b0, 32'h0, 1'b0);
    plan_item(ACT_FETCH, 12'hFFF, 12'hFFF, 32'h0, 1'b1, 32'h8004_0201, 1'b0);
    // A zero destination width puts every fetch out of range.
    plan_cfg(REG_DST_WIDTH, 13'd0);
    plan_item(ACT_FETCH, 12'd0, 12'd0, 32'h0, 1'b1, 32'h0, 1'b1);
    // One-pixel source stretched over an odd destination.
    plan_cfg(REG_SRC_WIDTH, 13'd1);
    plan_cfg(REG_SRC_HEIGHT, 13'd1);
    plan_cfg(REG_DST_WIDTH, 13'd3);
    plan_cfg(REG_DST_HEIGHT, 13'd4095);
    plan_item(ACT_WRITE, 12'd1, 12'd0, 32'hDEAD_BEEF, 1'b0, 32'h0, 1'b0);
    plan_item(ACT_WRITE, 12'd0, 12'd0, 32'h1234_5678, 1'b0, 32'h0, 1'b0);
    plan_item(ACT_FETCH, 12'd2, 12'd4094, 32'h0, 1'b0, 32'h0, 1'b0);
    plan_item(ACT_FETCH, 12'd3, 12'd0, 32'h0, 1'b1, 32'h0, 1'b1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    in_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        if (!in_cfg) begin
          wait_idle();
          size_settings++;
        end
        in_cfg = 1'b1;
        set_register(plan[i].reg_index, plan[i].reg_value);
      end else begin
        if (in_cfg) cfg_valid <= 1'b0;
        in_cfg = 1'b0;
        send_item(plan[i].item, plan[i].typed, plan[i].typed_result);
      end
    end

    base    = writes_stored + writes_ignored + fetches;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        new_sw = SRC_DIM_W'($urandom_range(16, 1));
        new_sh = SRC_DIM_W'($urandom_range(16, 1));
        new_dw = DST_DIM_W'($urandom_range(48, 1));
        new_dh = DST_DIM_W'($urandom_range(48, 1));
      end else if (pick < 75) begin
        new_sw = SRC_DIM_W'($urandom_range(256, 128));
        new_sh = SRC_DIM_W'($urandom_range(256, 128));
        new_dw = DST_DIM_W'($urandom_range(4096, 1));
        new_dh = DST_DIM_W'($urandom_range(4096, 1));
      end else if (pick < 88) begin
        case ($urandom_range(3))
          0: new_sw = '0;
          1: new_sw = SRC_DIM_W'(1);
          2: new_sw = SRC_DIM_W'(MAX_SRC_WIDTH);
          default: new_sw = SRC_DIM_W'($urandom_range(511, 257));
        endcase
        new_sh = SRC_DIM_W'($urandom_range(1) ? 1 : MAX_SRC_HEIGHT);
        case ($urandom_range(4))
          0: new_dw = '0;
          1: new_dw = DST_DIM_W'(1);
          2: new_dw = DST_DIM_W'(4095);
          3: new_dw = DST_DIM_W'(MAX_DST_DIM);
          default: new_dw = DST_DIM_W'($urandom_range(8191, 4097));
        endcase
        new_dh = DST_DIM_W'($urandom_range(1) ? 1 : $urandom_range(8191, 4095));
      end else begin
        new_sw = SRC_DIM_W'($urandom);
        new_sh = SRC_DIM_W'($urandom);
        new_dw = DST_DIM_W'($urandom);
        new_dh = DST_DIM_W'($urandom);
      end
      wait_idle();
      size_settings++;
      set_register(REG_SRC_WIDTH, CFG_DAT_W'(new_sw));
      set_register(REG_SRC_HEIGHT, CFG_DAT_W'(new_sh));
      set_register(REG_DST_WIDTH, new_dw);
      set_register(REG_DST_HEIGHT, new_dh);
      cfg_valid <= 1'b0;

      sw = clamp_dim(img_src_w, MAX_SRC_WIDTH);
      sh = clamp_dim(img_src_h, MAX_SRC_HEIGHT);
      dw = clamp_dim(img_dst_w, MAX_DST_DIM);
      dh = clamp_dim(img_dst_h, MAX_DST_DIM);
      phase_len = $urandom_range(60, 20);

      for (int n = 0; n < phase_len && counted < RANDOM_ITEMS; n++) begin
        steady_flow = (counted >= 300 && counted < 450);
        pick = $urandom_range(99);
        x    = COORD_W'($urandom_range(4095));
        y    = COORD_W'($urandom_range(4095));
        act  = ACT_FETCH;
        if (pick < 35) begin
          act = ACT_WRITE;
          if (sw != 0 && sh != 0) begin
            x = COORD_W'($urandom_range(sw - 1));
            y = COORD_W'($urandom_range(sh - 1));
          end
        end else if (pick < 80) begin
          if (dw != 0 && dh != 0) begin
            x = COORD_W'($urandom_range(dw - 1));
            y = COORD_W'($urandom_range(dh - 1));
          end
        end else if (pick < 88) begin
          // Step just past the destination edge, or far beyond it.
          if (dw <= 4095 && $urandom_range(1)) x = COORD_W'($urandom_range(4095, dw));
          else if (dh <= 4095) y = COORD_W'($urandom_range(4095, dh));
        end else if (pick < 94) begin
          act = ACT_WRITE;
          x   = COORD_W'($urandom_range(4095, sw));
        end else begin
          act = logic'($urandom_range(1));
        end
        it = pixel_item(act, x, y, $urandom);
        if (act == ACT_FETCH) begin
          // Never read a store entry that has not been written.
          a = fetch_addr(x, y);
          if (a >= 0 && !pixel_written[a])
            send_item(pixel_item(ACT_WRITE, COORD_W'(a % MAX_SRC_WIDTH),
                                 COORD_W'(a / MAX_SRC_WIDTH), $urandom), 1'b0, '0);
        end
        send_item(it, 1'b0, '0);
        counted = writes_stored + writes_ignored + fetches - base;
      end
    end
    steady_flow = 1'b0;

    in_valid <= 1'b0;
    for (int i = 0; i < 20000 && expected_pixels.size() != 0; i++) @(negedge clk);
    if (expected_pixels.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_pixels.size()));
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d fetches (%0d outside the destination), %0d stored and %0d ignored writes",
             fetches, fetches_outside, writes_stored, writes_ignored);
    $display("over %0d size settings; %0d mismatches found", size_settings, errors);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

### nearest_neighbor_image_scaler_unit.f
src/nnis_pkg.sv
src/nnis_ram.sv
src/nearest_neighbor_image_scaler_unit.sv
src/nnis_checker.sv
bench/nearest_neighbor_image_scaler_unit_tb.sv
